FILE: rtl/core/psa_pkg.sv
// Shared constants and types for the pixel saturation adjust block.
package psa_pkg;

    // Channel and arithmetic widths
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;
    localparam int SUM_W   = 32;
    localparam int ROOT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int DIFF_W  = ROOT_W + 2;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    // Accumulator covers the product and the brightness term for FRAC_BITS up to 16
    localparam int ACC_W   = 35;

    // Square root: one result bit per cell
    localparam int SQRT_STEPS = ROOT_W;

    // Perceived brightness weights, Q0.16 (they sum to 65536)
    localparam logic [SQ_W-1:0] W_RED   = 16'd19595;
    localparam logic [SQ_W-1:0] W_GREEN = 16'd38470;
    localparam logic [SQ_W-1:0] W_BLUE  = 16'd7471;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Gain defaults: Q4.12, 1.0 leaves the color unchanged
    localparam int                 FRAC_BITS_DEF = 12;
    localparam logic [GAIN_W-1:0]  GAIN_RESET    = 16'd4096;

    // One RGB pixel, red in the low bits
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix;

endpackage

FILE: rtl/core/psa_luma.sv
// Weighted sum of squared channels: three-stage pipeline giving S = sum(w * c^2).
module psa_luma (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  logic                        i_valid,
    input  psa_pkg::t_pix               i_pix,
    output logic                        o_valid,
    output psa_pkg::t_pix               o_pix,
    output logic [psa_pkg::SUM_W-1:0]   o_sum
);

    logic [psa_pkg::SQ_W-1:0]  r_sq_r, r_sq_g, r_sq_b;
    logic [psa_pkg::SUM_W-1:0] r_wp_r, r_wp_g, r_wp_b;
    logic [psa_pkg::SUM_W-1:0] r_sum;
    logic                      r_v1, r_v2, r_v3;
    psa_pkg::t_pix             r_pix1, r_pix2, r_pix3;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Square, weight, then add
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sq_r <= psa_pkg::SQ_W'(i_pix.red)   * psa_pkg::SQ_W'(i_pix.red);
            r_sq_g <= psa_pkg::SQ_W'(i_pix.green) * psa_pkg::SQ_W'(i_pix.green);
            r_sq_b <= psa_pkg::SQ_W'(i_pix.blue)  * psa_pkg::SQ_W'(i_pix.blue);
            r_pix1 <= i_pix;

            r_wp_r <= psa_pkg::SUM_W'(r_sq_r) * psa_pkg::SUM_W'(psa_pkg::W_RED);
            r_wp_g <= psa_pkg::SUM_W'(r_sq_g) * psa_pkg::SUM_W'(psa_pkg::W_GREEN);
            r_wp_b <= psa_pkg::SUM_W'(r_sq_b) * psa_pkg::SUM_W'(psa_pkg::W_BLUE);
            r_pix2 <= r_pix1;

            // Total never exceeds 32 bits
            r_sum  <= r_wp_r + r_wp_g + r_wp_b;
            r_pix3 <= r_pix2;
        end
    end

    assign o_valid = r_v3;
    assign o_pix   = r_pix3;
    assign o_sum   = r_sum;

endmodule

FILE: rtl/core/psa_sqrt_cell.sv
// One cell of the square-root chain: settles one bit of the root per stage.
module psa_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  logic                        i_valid,
    input  psa_pkg::t_pix               i_pix,
    input  logic [psa_pkg::SUM_W-1:0]   i_rem,
    input  logic [psa_pkg::SUM_W-1:0]   i_root,
    output logic                        o_valid,
    output psa_pkg::t_pix               o_pix,
    output logic [psa_pkg::SUM_W-1:0]   o_rem,
    output logic [psa_pkg::SUM_W-1:0]   o_root
);

    localparam logic [psa_pkg::SUM_W:0] BIT =
        (psa_pkg::SUM_W+1)'(1) << (psa_pkg::SUM_W - 2 - 2 * STEP);

    logic [psa_pkg::SUM_W:0]   w_trial;
    logic                      w_take;
    logic [psa_pkg::SUM_W-1:0] n_rem, n_root;
    logic                      r_valid;
    psa_pkg::t_pix             r_pix;
    logic [psa_pkg::SUM_W-1:0] r_rem, r_root;

    // Try the next root bit against the remainder
    always_comb begin
        w_trial = {1'b0, i_root} + BIT;
        w_take  = ({1'b0, i_rem} >= w_trial);
        if (w_take) begin
            n_rem  = psa_pkg::SUM_W'({1'b0, i_rem} - w_trial);
            n_root = (i_root >> 1) + BIT[psa_pkg::SUM_W-1:0];
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    // Hand state to the next cell
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pix  <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

FILE: rtl/core/psa_adjust_lane.sv
// One channel lane: scales the distance from brightness by the gain, floors and clamps.
module psa_adjust_lane #(
    parameter int FRAC_BITS = psa_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_ce,
    input  logic [psa_pkg::CH_W-1:0]           i_chan,
    input  logic [psa_pkg::ROOT_W-1:0]         i_root,
    input  logic signed [psa_pkg::GAIN_W-1:0]  i_gain,
    output logic [psa_pkg::CH_W-1:0]           o_chan
);

    localparam int BASE_W = psa_pkg::ROOT_W + FRAC_BITS;
    localparam int SHIFT  = psa_pkg::CH_W + FRAC_BITS;

    logic signed [psa_pkg::DIFF_W-1:0] w_diff;
    logic signed [psa_pkg::PROD_W-1:0] r_prod;
    logic [BASE_W-1:0]                 r_base;
    logic signed [psa_pkg::ACC_W-1:0]  w_acc;

    // Channel in Q8.8 minus brightness
    assign w_diff = $signed({2'b00, i_chan, 8'h00}) - $signed({2'b00, i_root});

    // Register product and brightness term
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= psa_pkg::PROD_W'(w_diff) * psa_pkg::PROD_W'(i_gain);
            r_base <= BASE_W'(i_root) << FRAC_BITS;
        end
    end

    assign w_acc = psa_pkg::ACC_W'(r_prod) + $signed(psa_pkg::ACC_W'(r_base));

    // Floor, then clamp to the channel range
    always_comb begin
        if (w_acc[psa_pkg::ACC_W-1]) begin
            o_chan = '0;
        end else if (|w_acc[psa_pkg::ACC_W-2:SHIFT+psa_pkg::CH_W]) begin
            o_chan = psa_pkg::CH_MAX;
        end else begin
            o_chan = w_acc[SHIFT+psa_pkg::CH_W-1:SHIFT];
        end
    end

endmodule

FILE: rtl/core/pixel_saturation_adjust.sv
// Top level: saturation adjustment of an RGB pixel stream around perceived brightness.
//
// Input stream s_axis carries one pixel per transaction: tdata = red [7:0], green [15:8],
// blue [23:16]. Output stream m_axis carries the adjusted pixel in the same layout.
// The gain is written through i_cfg_wr_en / i_cfg_wr_data (signed, FRAC_BITS fraction
// bits; 1.0 leaves the color unchanged, 0 gives grey, negative inverts the chroma).
// Write it only while no pixels are in flight.
// From input transaction to m_axis_tvalid a pixel passes three stages of squaring and
// weighting, sixteen square-root cells (one root bit each), one multiply stage per
// channel and the output register. Throughput is one pixel per clock while the pipeline
// is not frozen; every stage holds one pixel and all stages advance together.
// An output register with a one-entry skid buffer separates the two sides; s_axis_tready
// is registered and drops only once the skid buffer holds a pixel, which freezes the
// pipeline until the receiver takes the output.
// Reset (synchronous, active low) empties the pipeline and sets the gain to 1.0.
module pixel_saturation_adjust #(
    parameter int FRAC_BITS = psa_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_wr_en,
    input  logic [psa_pkg::GAIN_W-1:0]       i_cfg_wr_data,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [3*psa_pkg::CH_W-1:0]       s_axis_tdata,  // red_in, green_in, blue_in
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [3*psa_pkg::CH_W-1:0]       m_axis_tdata   // red_out, green_out, blue_out
);

    localparam int N = psa_pkg::SQRT_STEPS;

    logic                             w_ce;
    logic                             w_push;
    logic [psa_pkg::GAIN_W-1:0]       r_gain;
    logic                             w_luma_valid;
    psa_pkg::t_pix                    w_luma_pix;
    logic [psa_pkg::SUM_W-1:0]        w_luma_sum;
    logic                             w_valid [0:N];
    psa_pkg::t_pix                    w_pix   [0:N];
    logic [psa_pkg::SUM_W-1:0]        w_rem   [0:N];
    logic [psa_pkg::SUM_W-1:0]        w_root  [0:N];
    logic                             r_adj_valid;
    psa_pkg::t_pix                    w_res;
    logic                             r_out_valid, r_skid_valid;
    psa_pkg::t_pix                    r_out, r_skid;

    // Pipeline advances while the skid buffer is empty
    assign w_ce          = !r_skid_valid;
    assign s_axis_tready = w_ce;
    assign w_push        = w_ce && r_adj_valid;

    // Hold the gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= psa_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    psa_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (s_axis_tvalid),
        .i_pix   (psa_pkg::t_pix'(s_axis_tdata)),
        .o_valid (w_luma_valid),
        .o_pix   (w_luma_pix),
        .o_sum   (w_luma_sum)
    );

    assign w_valid[0] = w_luma_valid;
    assign w_pix[0]   = w_luma_pix;
    assign w_rem[0]   = w_luma_sum;
    assign w_root[0]  = '0;

    // Square-root chain
    for (genvar k = 0; k < N; k++) begin : g_sqrt
        psa_sqrt_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (w_valid[k]),
            .i_pix   (w_pix[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .o_valid (w_valid[k+1]),
            .o_pix   (w_pix[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_valid <= 1'b0;
        end else if (w_ce) begin
            r_adj_valid <= w_valid[N];
        end
    end

    // Per-channel adjust lanes
    psa_adjust_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_chan (w_pix[N].red),
        .i_root (w_root[N][psa_pkg::ROOT_W-1:0]),
        .i_gain ($signed(r_gain)),
        .o_chan (w_res.red)
    );

    psa_adjust_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_chan (w_pix[N].green),
        .i_root (w_root[N][psa_pkg::ROOT_W-1:0]),
        .i_gain ($signed(r_gain)),
        .o_chan (w_res.green)
    );

    psa_adjust_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_chan (w_pix[N].blue),
        .i_root (w_root[N][psa_pkg::ROOT_W-1:0]),
        .i_gain ($signed(r_gain)),
        .o_chan (w_res.blue)
    );

    // Output register with skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    // Skid buffer fills only behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a pixel while output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready && r_adj_valid))
        else $error("skid buffer filled without a stalled output");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_push)
        else $error("pixel pushed while skid buffer is full");

    a_gain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_wr_en) && $past(i_rst_n) |-> $stable(r_gain))
        else $error("gain changed without a configuration write");
`endif

endmodule

FILE: dv/testbench.sv
// Testbench for pixel_saturation_adjust: self-checking stream test with random flow control.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS     = psa_pkg::FRAC_BITS_DEF;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_PIXELS = 1400;
    localparam int REPORT_MAX    = 10;

    // Brightness-referenced saturation predictor with an ordered store of expected pixels
    class saturation_checker;
        logic signed [psa_pkg::GAIN_W-1:0] gain;
        psa_pkg::t_pix                     expected_pixels[$];
        int                                mismatches;

        function new();
            gain       = psa_pkg::GAIN_RESET;
            mismatches = 0;
        endfunction

        function void set_gain(logic [psa_pkg::GAIN_W-1:0] value);
            gain = value;
        endfunction

        // Integer square root by setting result bits from the top down
        function automatic logic [psa_pkg::ROOT_W-1:0] root_of(
                logic [psa_pkg::SUM_W-1:0] sum);
            logic [psa_pkg::ROOT_W-1:0] root;
            logic [psa_pkg::ROOT_W-1:0] trial;
            root = '0;
            for (int i = psa_pkg::ROOT_W - 1; i >= 0; i--) begin
                trial = root | (psa_pkg::ROOT_W'(1) << i);
                if (64'(trial) * 64'(trial) <= 64'(sum))
                    root = trial;
            end
            return root;
        endfunction

        // Move one channel away from brightness by the gain, floor and clamp
        function automatic logic [psa_pkg::CH_W-1:0] shift_channel(
                logic [psa_pkg::CH_W-1:0] chan, logic [psa_pkg::ROOT_W-1:0] bright);
            longint acc;
            longint lvl;
            acc = longint'(bright) * (longint'(1) << FRAC_BITS)
                + (longint'(chan) * 256 - longint'(bright)) * longint'(gain);
            if (acc < 0)
                return '0;
            lvl = acc >>> (8 + FRAC_BITS);
            if (lvl > longint'(psa_pkg::CH_MAX))
                return psa_pkg::CH_MAX;
            return lvl[psa_pkg::CH_W-1:0];
        endfunction

        function automatic psa_pkg::t_pix predict_pixel(psa_pkg::t_pix pix);
            logic [psa_pkg::SUM_W-1:0]  sum;
            logic [psa_pkg::ROOT_W-1:0] bright;
            psa_pkg::t_pix              res;
            sum = psa_pkg::SUM_W'(psa_pkg::W_RED) * psa_pkg::SUM_W'(pix.red)
                    * psa_pkg::SUM_W'(pix.red)
                + psa_pkg::SUM_W'(psa_pkg::W_GREEN) * psa_pkg::SUM_W'(pix.green)
                    * psa_pkg::SUM_W'(pix.green)
                + psa_pkg::SUM_W'(psa_pkg::W_BLUE) * psa_pkg::SUM_W'(pix.blue)
                    * psa_pkg::SUM_W'(pix.blue);
            bright    = root_of(sum);
            res.red   = shift_channel(pix.red, bright);
            res.green = shift_channel(pix.green, bright);
            res.blue  = shift_channel(pix.blue, bright);
            return res;
        endfunction

        function void note_pixel(psa_pkg::t_pix pix);
            expected_pixels.push_back(predict_pixel(pix));
        endfunction

        function void flag(string what, int want, int got);
            if (mismatches < REPORT_MAX)
                $display("mismatch %s: expected %0d, actual %0d", what, want, got);
            mismatches++;
        endfunction

        function void check_pixel(psa_pkg::t_pix got);
            psa_pkg::t_pix want;
            if (expected_pixels.size() == 0) begin
                flag("unexpected pixel (red)", -1, got.red);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.red)     flag("red", want.red, got.red);
            if (got.green !== want.green) flag("green", want.green, got.green);
            if (got.blue !== want.blue)   flag("blue", want.blue, got.blue);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_wr_en   = 1'b0;
    logic [psa_pkg::GAIN_W-1:0]   i_cfg_wr_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [3*psa_pkg::CH_W-1:0]   s_axis_tdata  = '0;  // red_in, green_in, blue_in
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [3*psa_pkg::CH_W-1:0]   m_axis_tdata;        // red_out, green_out, blue_out

    saturation_checker checker_h = new();
    int                idle_cycles = 0;

    pixel_saturation_adjust #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver: rotate a stall pattern, pick a fresh one whenever the age counter wraps
    always @(posedge i_clk) begin
        static logic [15:0] rdy_pat = 16'hFFFF;
        static int          rdy_age = 0;
        if (rdy_age == 0) begin
            case ($urandom_range(0, 4))
                0, 1: rdy_pat = 16'hFFFF;
                2:    rdy_pat = 16'($urandom()) | 16'h0001;
                3:    rdy_pat = 16'h0001;
                default: rdy_pat = 16'hF0F0;
            endcase
        end
        rdy_age       = (rdy_age + 1) % 256;
        m_axis_tready <= rdy_pat[0];
        rdy_pat       = {rdy_pat[0], rdy_pat[15:1]};
    end

    // Check every output transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            checker_h.check_pixel(psa_pkg::t_pix'(m_axis_tdata));
    end

    // Watchdog: end the run when no transaction happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one pixel and hold it until the transaction completes
    task automatic send_pixel(psa_pkg::t_pix pix);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        checker_h.note_pixel(pix);
    endtask

    task automatic pause_input(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic drain_output();
        s_axis_tvalid <= 1'b0;
        while (checker_h.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_gain(logic [psa_pkg::GAIN_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        checker_h.set_gain(value);
        @(posedge i_clk);
    endtask

    function automatic logic [psa_pkg::CH_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return psa_pkg::CH_MAX;
            2:       return psa_pkg::CH_W'($urandom_range(0, 3));
            default: return psa_pkg::CH_MAX - psa_pkg::CH_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic psa_pkg::t_pix random_pixel();
        psa_pkg::t_pix pix;
        int            base;
        case ($urandom_range(0, 9))
            // near grey: channels close to one another
            0, 1: begin
                base      = $urandom_range(0, 255);
                pix.red   = psa_pkg::CH_W'(base);
                pix.green = psa_pkg::CH_W'(base) + psa_pkg::CH_W'($urandom_range(0, 4));
                pix.blue  = psa_pkg::CH_W'(base) - psa_pkg::CH_W'($urandom_range(0, 4));
            end
            // channels at or near the range ends
            2, 3: begin
                pix.red   = pick_extreme();
                pix.green = pick_extreme();
                pix.blue  = pick_extreme();
            end
            default: begin
                pix.red   = psa_pkg::CH_W'($urandom_range(0, 255));
                pix.green = psa_pkg::CH_W'($urandom_range(0, 255));
                pix.blue  = psa_pkg::CH_W'($urandom_range(0, 255));
            end
        endcase
        return pix;
    endfunction

    task automatic send_corner_pixels();
        psa_pkg::t_pix corners[12];
        corners[0]  = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
        corners[1]  = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        corners[2]  = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
        corners[3]  = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
        corners[4]  = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
        corners[5]  = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
        corners[6]  = '{blue: 8'd255, green: 8'd255, red: 8'd0};
        corners[7]  = '{blue: 8'd255, green: 8'd0,   red: 8'd255};
        corners[8]  = '{blue: 8'd3,   green: 8'd2,   red: 8'd1};
        corners[9]  = '{blue: 8'd128, green: 8'd128, red: 8'd128};
        corners[10] = '{blue: 8'd127, green: 8'd1,   red: 8'd254};
        corners[11] = '{blue: 8'hAA,  green: 8'h55,  red: 8'hAA};
        foreach (corners[i]) begin
            send_pixel(corners[i]);
            if ($urandom_range(0, 2) == 0)
                pause_input($urandom_range(1, 3));
        end
    endtask

    // Random pixels in bursts separated by random gaps
    task automatic send_random_pixels(int count);
        int burst_left;
        burst_left = $urandom_range(1, 40);
        repeat (count) begin
            send_pixel(random_pixel());
            burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    pause_input($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // Main sequence: reset, then one phase per gain setting
    initial begin
        logic [psa_pkg::GAIN_W-1:0] gains[11];
        int                         per_phase;
        gains[0]  = psa_pkg::GAIN_RESET;
        gains[1]  = 16'h0000;
        gains[2]  = 16'h7FFF;
        gains[3]  = 16'h8000;
        gains[4]  = 16'hFFFF;
        gains[5]  = 16'd8192;
        gains[6]  = -16'sd4096;
        gains[7]  = 16'h0001;
        gains[8]  = 16'($urandom());
        gains[9]  = 16'($urandom_range(0, 16384)) - 16'd8192;
        gains[10] = psa_pkg::GAIN_RESET;
        per_phase = RANDOM_PIXELS / 11;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (gains[ph]) begin
            // the first phase runs on the reset gain
            if (ph != 0)
                write_gain(gains[ph]);
            if (ph == 0 || ph == 3)
                send_corner_pixels();
            send_random_pixels(per_phase);
            drain_output();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
